@@ hw/rtl/sfd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and register map for the sample frame deframer.
package sfd_pkg;

  localparam int unsigned ChannelsDefault = 32;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned ChanW     = 6;
  localparam int unsigned TripleW   = 7;
  localparam int unsigned RunW      = 3;
  localparam int unsigned SampRawW  = 16;
  localparam int unsigned SampleW   = 24;
  localparam int unsigned TimeW     = 42;
  localparam int unsigned EventW    = 9;
  localparam int unsigned GainW     = 16;
  localparam int unsigned OffsetW   = 24;
  localparam int unsigned CoefW     = 24;
  localparam int unsigned StateW    = 32;
  localparam int unsigned PaddrW    = 4;
  localparam int unsigned PdataW    = 32;
  localparam int unsigned OutTdataW = 88;

  // Hunt run length that ends the timestamp (six marked bytes).
  localparam logic [RunW-1:0] HuntLastPos = 3'd5;

  localparam logic [GainW-1:0]   GainReset   = 16'd12498;
  localparam logic [OffsetW-1:0] OffsetReset = 24'd768000;
  localparam logic [CoefW-1:0]   CoefReset   = 24'd16775357;

  typedef enum logic [3:0] {
    ST_HUNT,
    ST_TTL_IN,
    ST_TTL_OUT,
    ST_DATA,
    ST_MUL_GAIN,
    ST_CUR,
    ST_MUL_B,
    ST_MUL_A,
    ST_FINISH
  } sfd_state_e;

  typedef enum logic [1:0] {
    REG_GAIN   = 2'd0,
    REG_OFFSET = 2'd1,
    REG_COEF   = 2'd2
  } sfd_reg_e;

  typedef struct packed {
    logic [GainW-1:0]   gain;
    logic [OffsetW-1:0] offset;
    logic [CoefW-1:0]   coef;
  } sfd_cfg_t;

  typedef struct packed {
    logic             hunt_clear;
    logic             hunt_load;
    logic [RunW-1:0]  hunt_pos;
    logic             ttl_in_load;
    logic             ttl_out_load;
    logic             hi_load;
    logic             lo_load;
    logic             capture;
    logic [ChanW-1:0] channel;
    logic             last;
    logic             mul_gain;
    logic             cur_load;
    logic             mul_b;
    logic             mul_a;
    logic             finish;
  } sfd_cmd_t;

endpackage

@@ hw/rtl/sample_frame_deframer_highpass.sv @@
`timescale 1ns / 1ps
// Top level: acquisition byte-stream deframer with per-channel high-pass filter.
// Throughput: one byte per cycle through hunt, TTL and unused bytes; the byte that
//   closes a used triple stalls the input while the shared sequence (gain multiply,
//   offset, B multiply, A multiply, state update) runs; the state update waits
//   until the output register is free of the previous beat, which the downstream
//   side may still hold, and then loads the result beat into it.
// Reset (rst_ni, async low): hunting, counters and header clear, all filter
//   states read as zero via per-channel valid bits; registers take reset values.
module sample_frame_deframer_highpass #(
  parameter int unsigned CHANNELS = sfd_pkg::ChannelsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input byte stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [sfd_pkg::ByteW-1:0]        s_axis_tdata,   // [7:0] data_byte
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [5:0] channel, [29:6] filtered_sample, [71:30] frame_time,
  // [80:72] event_code, [87:81] zero
  output logic [sfd_pkg::OutTdataW-1:0]    m_axis_tdata,
  output logic                             m_axis_tlast,   // last_channel
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sfd_pkg::PaddrW-1:0]       paddr,
  input  logic [sfd_pkg::PdataW-1:0]       pwdata,
  output logic [sfd_pkg::PdataW-1:0]       prdata,
  output logic                             pready
);

  sfd_pkg::sfd_cfg_t                    cfg;
  sfd_pkg::sfd_cmd_t                    cmd;
  logic                                 out_free;
  logic [sfd_pkg::ChanW-1:0]            out_channel;
  logic signed [sfd_pkg::SampleW-1:0]   out_sample;
  logic [sfd_pkg::TimeW-1:0]            out_time;
  logic [sfd_pkg::EventW-1:0]           out_event;

  // gain at 0x0, offset at 0x4, filter pole at 0x8
  sfd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // walks hunt -> TTL in -> TTL out -> triples, and sequences each used sample
  sfd_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_data_i  (s_axis_tdata),
    .out_free_i (out_free),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  // holds header fields, filter state memory and the output register
  sfd_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_data_i     (s_axis_tdata),
    .cmd_i         (cmd),
    .cfg_i         (cfg),
    .out_ready_i   (m_axis_tready),
    .out_free_o    (out_free),
    .out_valid_o   (m_axis_tvalid),
    .out_last_o    (m_axis_tlast),
    .out_channel_o (out_channel),
    .out_sample_o  (out_sample),
    .out_time_o    (out_time),
    .out_event_o   (out_event)
  );

  assign m_axis_tdata = {7'd0, out_event, out_time, out_sample, out_channel};

endmodule

@@ hw/rtl/sfd_regs.sv @@
`timescale 1ns / 1ps
// APB register file holding gain, offset and filter coefficient.
module sfd_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sfd_pkg::PaddrW-1:0]   paddr,
  input  logic [sfd_pkg::PdataW-1:0]   pwdata,
  output logic [sfd_pkg::PdataW-1:0]   prdata,
  output logic                         pready,
  output sfd_pkg::sfd_cfg_t            cfg_o
);

  logic [sfd_pkg::GainW-1:0]   gain_q, gain_d;
  logic [sfd_pkg::OffsetW-1:0] offset_q, offset_d;
  logic [sfd_pkg::CoefW-1:0]   coef_q, coef_d;
  logic                        wr_en;
  logic [1:0]                  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];

  always_comb begin
    gain_d   = gain_q;
    offset_d = offset_q;
    coef_d   = coef_q;
    if (wr_en) begin
      case (reg_idx)
        sfd_pkg::REG_GAIN:   gain_d   = pwdata[sfd_pkg::GainW-1:0];
        sfd_pkg::REG_OFFSET: offset_d = pwdata[sfd_pkg::OffsetW-1:0];
        sfd_pkg::REG_COEF:   coef_d   = pwdata[sfd_pkg::CoefW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      sfd_pkg::REG_GAIN:   prdata = {16'd0, gain_q};
      sfd_pkg::REG_OFFSET: prdata = {8'd0, offset_q};
      sfd_pkg::REG_COEF:   prdata = {8'd0, coef_q};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= sfd_pkg::GainReset;
      offset_q <= sfd_pkg::OffsetReset;
      coef_q   <= sfd_pkg::CoefReset;
    end else begin
      gain_q   <= gain_d;
      offset_q <= offset_d;
      coef_q   <= coef_d;
    end
  end

  assign cfg_o.gain   = gain_q;
  assign cfg_o.offset = offset_q;
  assign cfg_o.coef   = coef_q;

endmodule

@@ hw/rtl/sfd_ctrl.sv @@
`timescale 1ns / 1ps
// Frame parser and compute sequencer for the deframer.
module sfd_ctrl #(
  parameter int unsigned CHANNELS = sfd_pkg::ChannelsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [sfd_pkg::ByteW-1:0]   in_data_i,
  input  logic                        out_free_i,
  output logic                        in_ready_o,
  output sfd_pkg::sfd_cmd_t           cmd_o
);

  localparam logic [sfd_pkg::TripleW:0] Triples = (sfd_pkg::TripleW + 1)'(2 * CHANNELS);

  sfd_pkg::sfd_state_e            state_q, state_d;
  logic [sfd_pkg::RunW-1:0]       run_q, run_d;
  logic [1:0]                     pos_q, pos_d;
  logic [sfd_pkg::TripleW-1:0]    tri_q, tri_d;
  logic                           accept;
  logic [sfd_pkg::TripleW:0]      tri_inc;
  logic [sfd_pkg::TripleW:0]      tri_plus2;

  assign tri_inc   = {1'b0, tri_q} + 8'd1;
  assign tri_plus2 = {1'b0, tri_q} + 8'd2;

  always_comb begin
    state_d    = state_q;
    run_d      = run_q;
    pos_d      = pos_q;
    tri_d      = tri_q;
    cmd_o      = '0;
    cmd_o.hunt_pos = run_q;
    cmd_o.channel  = tri_q[sfd_pkg::TripleW-1:1];
    cmd_o.last     = (tri_plus2 >= Triples);
    in_ready_o = state_q inside {sfd_pkg::ST_HUNT, sfd_pkg::ST_TTL_IN,
                                 sfd_pkg::ST_TTL_OUT, sfd_pkg::ST_DATA};
    accept     = in_valid_i && in_ready_o;

    case (state_q)
      sfd_pkg::ST_HUNT: begin
        if (accept) begin
          if (in_data_i[0]) begin
            cmd_o.hunt_load = 1'b1;
            if (run_q == sfd_pkg::HuntLastPos) begin
              run_d   = '0;
              state_d = sfd_pkg::ST_TTL_IN;
            end else begin
              run_d = run_q + 3'd1;
            end
          end else begin
            cmd_o.hunt_clear = 1'b1;
            run_d            = '0;
          end
        end
      end
      sfd_pkg::ST_TTL_IN: begin
        if (accept) begin
          cmd_o.ttl_in_load = 1'b1;
          state_d           = sfd_pkg::ST_TTL_OUT;
        end
      end
      sfd_pkg::ST_TTL_OUT: begin
        if (accept) begin
          cmd_o.ttl_out_load = 1'b1;
          tri_d              = '0;
          pos_d              = '0;
          state_d            = sfd_pkg::ST_DATA;
        end
      end
      sfd_pkg::ST_DATA: begin
        if (accept) begin
          case (pos_q)
            2'd0: begin
              cmd_o.hi_load = 1'b1;
              pos_d         = 2'd1;
            end
            2'd1: begin
              cmd_o.lo_load = 1'b1;
              pos_d         = 2'd2;
            end
            default: begin
              pos_d = 2'd0;
              tri_d = tri_inc[sfd_pkg::TripleW-1:0];
              // only even triples carry a used channel
              if (!tri_q[0]) begin
                cmd_o.capture = 1'b1;
                state_d       = sfd_pkg::ST_MUL_GAIN;
              end
              if (tri_inc >= Triples) begin
                tri_d   = '0;
                run_d   = '0;
                state_d = sfd_pkg::ST_HUNT;
              end
            end
          endcase
        end
      end
      sfd_pkg::ST_MUL_GAIN: begin
        cmd_o.mul_gain = 1'b1;
        state_d        = sfd_pkg::ST_CUR;
      end
      sfd_pkg::ST_CUR: begin
        cmd_o.cur_load = 1'b1;
        state_d        = sfd_pkg::ST_MUL_B;
      end
      sfd_pkg::ST_MUL_B: begin
        cmd_o.mul_b = 1'b1;
        state_d     = sfd_pkg::ST_MUL_A;
      end
      sfd_pkg::ST_MUL_A: begin
        cmd_o.mul_a = 1'b1;
        state_d     = sfd_pkg::ST_FINISH;
      end
      sfd_pkg::ST_FINISH: begin
        if (out_free_i) begin
          cmd_o.finish = 1'b1;
          state_d      = sfd_pkg::ST_DATA;
        end
      end
      default: state_d = sfd_pkg::ST_HUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfd_pkg::ST_HUNT;
      run_q   <= '0;
      pos_q   <= '0;
      tri_q   <= '0;
    end else begin
      state_q <= state_d;
      run_q   <= run_d;
      pos_q   <= pos_d;
      tri_q   <= tri_d;
    end
  end

  a_finish_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> out_free_i)
    else $error("result finished while output register busy");

  a_triple_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, tri_q} < Triples))
    else $error("triple index past end of frame");

  a_capture_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> !in_ready_o ##1 !in_ready_o)
    else $error("input accepted during sample computation");

endmodule

@@ hw/rtl/sfd_dp.sv @@
`timescale 1ns / 1ps
// Datapath: header capture, sample scaling, high-pass filter and result register.
module sfd_dp #(
  parameter int unsigned CHANNELS = sfd_pkg::ChannelsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [sfd_pkg::ByteW-1:0]          in_data_i,
  input  sfd_pkg::sfd_cmd_t                  cmd_i,
  input  sfd_pkg::sfd_cfg_t                  cfg_i,
  input  logic                               out_ready_i,
  output logic                               out_free_o,
  output logic                               out_valid_o,
  output logic                               out_last_o,
  output logic [sfd_pkg::ChanW-1:0]          out_channel_o,
  output logic signed [sfd_pkg::SampleW-1:0] out_sample_o,
  output logic [sfd_pkg::TimeW-1:0]          out_time_o,
  output logic [sfd_pkg::EventW-1:0]         out_event_o
);

  localparam int unsigned ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // header and triple capture
  logic [sfd_pkg::TimeW-1:0]    time_q, time_d;
  logic [sfd_pkg::EventW-1:0]   event_q, event_d;
  logic [sfd_pkg::ByteW-1:0]    held_hi_q, held_lo_q;
  logic [sfd_pkg::SampRawW-1:0] samp_q;
  logic [sfd_pkg::ChanW-1:0]    ch_q;
  logic                         last_q;
  logic [sfd_pkg::TimeW-1:0]    time_part;
  logic [sfd_pkg::TimeW-1:0]    time_base;
  logic [5:0]                   time_shift;
  logic [ChIdxW-1:0]            ch_idx;

  // arithmetic
  logic [31:0]                  prod_q;
  logic [24:0]                  rnd;
  logic signed [25:0]           cur;
  logic signed [31:0]           cur64_q;
  logic signed [31:0]           st_raw_q, st_q;
  logic                         st_vld_q;
  logic [24:0]                  b_coef;
  logic signed [57:0]           pb_q, pa_q;
  logic signed [57:0]           sum;
  logic signed [33:0]           diff;
  logic signed [27:0]           o_full;
  logic signed [sfd_pkg::SampleW-1:0] o_sat;

  // per-channel filter state
  logic [sfd_pkg::StateW-1:0]   st_mem [CHANNELS];
  logic [CHANNELS-1:0]          st_valid_q;

  // result register
  logic                                out_valid_q;
  logic                                out_last_q;
  logic [sfd_pkg::ChanW-1:0]           out_channel_q;
  logic signed [sfd_pkg::SampleW-1:0]  out_sample_q;
  logic [sfd_pkg::TimeW-1:0]           out_time_q;
  logic [sfd_pkg::EventW-1:0]          out_event_q;

  assign ch_idx = ch_q[ChIdxW-1:0];

  // timestamp: seven bits per marked byte, first byte lowest
  assign time_part  = {35'd0, in_data_i[7:1]};
  assign time_shift = 6'd7 * {3'd0, cmd_i.hunt_pos};
  assign time_base  = (cmd_i.hunt_pos == '0) ? '0 : time_q;

  always_comb begin
    time_d  = time_q;
    event_d = event_q;
    if (cmd_i.hunt_clear) begin
      time_d = '0;
    end else if (cmd_i.hunt_load) begin
      time_d = time_base | (time_part << time_shift);
    end
    if (cmd_i.ttl_in_load) begin
      event_d = {1'b0, in_data_i};
    end else if (cmd_i.ttl_out_load && (in_data_i != '0)) begin
      event_d = event_q | 9'h100;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      time_q  <= '0;
      event_q <= '0;
    end else begin
      time_q  <= time_d;
      event_q <= event_d;
    end
  end

  // scaling: round(samp*gain / 256) - offset, then times 64
  assign rnd = 25'(({1'b0, prod_q} + 33'd128) >> 8);
  assign cur = $signed({1'b0, rnd}) - $signed({2'b00, cfg_i.offset});

  // B = 2^24 - A
  assign b_coef = 25'h1000000 - {1'b0, cfg_i.coef};

  assign sum    = pb_q + pa_q + 58'sd8388608;
  assign diff   = 34'(cur64_q) - 34'(st_q) + 34'sd32;
  assign o_full = diff[33:6];

  always_comb begin
    if (o_full > 28'sd8388607) begin
      o_sat = 24'sh7FFFFF;
    end else if (o_full < -28'sd8388608) begin
      o_sat = 24'sh800000;
    end else begin
      o_sat = o_full[23:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hi_load) begin
      held_hi_q <= in_data_i;
    end
    if (cmd_i.lo_load) begin
      held_lo_q <= in_data_i;
    end
    if (cmd_i.capture) begin
      // repair bits ride in bits 2 and 1 of the third byte
      samp_q <= {held_hi_q[7:1], held_hi_q[0] | in_data_i[2],
                 held_lo_q[7:1], held_lo_q[0] | in_data_i[1]};
      ch_q   <= cmd_i.channel;
      last_q <= cmd_i.last;
    end
    if (cmd_i.mul_gain) begin
      prod_q   <= samp_q * cfg_i.gain;
      st_raw_q <= st_mem[ch_idx];
      st_vld_q <= st_valid_q[ch_idx];
    end
    if (cmd_i.cur_load) begin
      cur64_q <= {cur, 6'd0};
      st_q    <= st_vld_q ? st_raw_q : '0;
    end
    if (cmd_i.mul_b) begin
      pb_q <= $signed({1'b0, b_coef}) * cur64_q;
    end
    if (cmd_i.mul_a) begin
      pa_q <= $signed({1'b0, cfg_i.coef}) * st_q;
    end
    if (cmd_i.finish) begin
      st_mem[ch_idx] <= sum[55:24];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_valid_q <= '0;
    end else if (cmd_i.finish) begin
      st_valid_q[ch_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_last_q    <= last_q;
      out_channel_q <= ch_q;
      out_sample_q  <= o_sat;
      out_time_q    <= time_q;
      out_event_q   <= event_q;
    end
  end

  assign out_free_o    = !out_valid_q || out_ready_i;
  assign out_valid_o   = out_valid_q;
  assign out_last_o    = out_last_q;
  assign out_channel_o = out_channel_q;
  assign out_sample_o  = out_sample_q;
  assign out_time_o    = out_time_q;
  assign out_event_o   = out_event_q;

  a_finish_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> out_valid_q && (out_channel_q == $past(ch_q)))
    else $error("result register not loaded with finished channel");

endmodule

@@ bench/tb_sample_frame_deframer_highpass.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the byte-stream deframer and per-channel high-pass filter.
module tb_sample_frame_deframer_highpass;
  import sfd_pkg::*;

  localparam int unsigned Channels    = ChannelsDefault;
  localparam int unsigned Triples     = 2 * Channels;
  // Extra cycles after the last expected beat: the block keeps computing past the
  // closing byte of a used triple, so this covers a byte still in flight.
  localparam int unsigned DrainCycles = 16;

  // m_axis_tdata layout, lowest field first
  localparam int unsigned SampleLsb = ChanW;
  localparam int unsigned StampLsb  = SampleLsb + SampleW;
  localparam int unsigned TtlLsb    = StampLsb + TimeW;
  localparam int unsigned PadLsb    = TtlLsb + EventW;

  typedef struct packed {
    logic [ChanW-1:0]   channel;
    logic [SampleW-1:0] sample;
    logic [TimeW-1:0]   stamp;
    logic [EventW-1:0]  ttl_code;
    logic               last;
  } sample_beat_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT
  // ---------------------------------------------------------------------------
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #10 clk_i = ~clk_i;

  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [ByteW-1:0]     s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [PaddrW-1:0]    paddr   = '0;
  logic [PdataW-1:0]    pwdata  = '0;
  logic [PdataW-1:0]    prdata;
  logic                 pready;

  sample_frame_deframer_highpass #(
    .CHANNELS(Channels)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // ---------------------------------------------------------------------------
  // Shared bookkeeping
  // ---------------------------------------------------------------------------
  int unsigned  error_count   = 0;
  int unsigned  src_idle_pct  = 0;   // chance per cycle that the byte source holds off
  int unsigned  snk_stall_pct = 0;   // chance per cycle that the result sink stalls
  sample_beat_t pending_samples[$];  // filtered samples predicted, not yet seen

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns mismatch: %s got 0x%0h want 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Deframer prediction: own copy of the registers and the framing/filter state
  // ---------------------------------------------------------------------------
  longint       gain_m     = GainReset;
  longint       offset_m   = OffsetReset;
  longint       coef_m     = CoefReset;
  sfd_state_e   phase_m    = ST_HUNT;
  int unsigned  odd_run_m  = 0;
  logic [TimeW-1:0]  stamp_m = '0;
  logic [EventW-1:0] ttl_m   = '0;
  int unsigned  triple_m   = 0;
  int unsigned  pos_m      = 0;    // byte position inside the current triple
  logic [7:0]   held_hi_m  = '0;
  logic [7:0]   held_lo_m  = '0;
  int           filt_m[Channels] = '{default: 0};  // Q.6 microvolts

  // Advance the framing state by one accepted byte; queue a beat when a used
  // (even) triple closes.
  function automatic void deframe_byte(input logic [7:0] b);
    sample_beat_t beat;
    logic [7:0]   hi;
    logic [7:0]   lo;
    longint       samp;
    longint       cur;
    longint       st;
    longint       pole_a;
    longint       pole_b;
    longint       o;
    longint       ns;
    int unsigned  ch;
    case (phase_m)
      ST_HUNT: begin
        if (b[0]) begin
          // first marked byte restarts the stamp, later ones fill 7 bits each
          if (odd_run_m == 0) stamp_m = TimeW'(b[7:1]);
          else stamp_m = stamp_m | (TimeW'(b[7:1]) << (7 * odd_run_m));
          odd_run_m++;
          if (odd_run_m >= 6) begin
            odd_run_m = 0;
            phase_m   = ST_TTL_IN;
          end
        end else begin
          odd_run_m = 0;
          stamp_m   = '0;
        end
      end
      ST_TTL_IN: begin
        ttl_m   = {1'b0, b};
        phase_m = ST_TTL_OUT;
      end
      ST_TTL_OUT: begin
        if (b != 8'h00) ttl_m[8] = 1'b1;
        triple_m = 0;
        pos_m    = 0;
        phase_m  = ST_DATA;
      end
      default: begin
        if (pos_m == 0) begin
          held_hi_m = b;
          pos_m     = 1;
        end else if (pos_m == 1) begin
          held_lo_m = b;
          pos_m     = 2;
        end else begin
          pos_m = 0;
          if (triple_m % 2 == 0) begin
            ch     = (triple_m / 2) % Channels;
            // repair bits: bit 2 into the high byte, bit 1 into the low byte
            hi     = held_hi_m | {7'd0, b[2]};
            lo     = held_lo_m | {7'd0, b[1]};
            samp   = {48'd0, hi, lo};
            cur    = ((samp * gain_m + 128) >>> 8) - offset_m;
            st     = filt_m[ch];
            pole_a = coef_m;
            pole_b = (longint'(1) << 24) - pole_a;
            o      = (cur * 64 - st + 32) >>> 6;
            ns     = (pole_b * (cur * 64) + pole_a * st + (longint'(1) << 23)) >>> 24;
            if (o > 8388607) o = 8388607;
            if (o < -8388608) o = -8388608;
            filt_m[ch]     = int'(ns);
            beat.channel  = ch[ChanW-1:0];
            beat.sample   = o[SampleW-1:0];
            beat.stamp    = stamp_m;
            beat.ttl_code = ttl_m;
            beat.last     = (triple_m + 2 >= Triples);
            pending_samples.push_back(beat);
          end
          triple_m++;
          if (triple_m >= Triples) begin
            triple_m  = 0;
            odd_run_m = 0;
            phase_m   = ST_HUNT;
          end
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stalls and the field-by-field check
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    sample_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_samples.size() == 0) begin
        report_mismatch("result beat with none expected", m_axis_tdata[63:0], '0);
      end else begin
        want = pending_samples.pop_front();
        if (m_axis_tdata[ChanW-1:0] != want.channel)
          report_mismatch("channel", m_axis_tdata[ChanW-1:0], want.channel);
        if (m_axis_tdata[SampleLsb +: SampleW] != want.sample)
          report_mismatch("filtered_sample", m_axis_tdata[SampleLsb +: SampleW],
                          want.sample);
        if (m_axis_tdata[StampLsb +: TimeW] != want.stamp)
          report_mismatch("frame_time", m_axis_tdata[StampLsb +: TimeW], want.stamp);
        if (m_axis_tdata[TtlLsb +: EventW] != want.ttl_code)
          report_mismatch("event_code", m_axis_tdata[TtlLsb +: EventW], want.ttl_code);
        if (m_axis_tdata[OutTdataW-1:PadLsb] != '0)
          report_mismatch("tdata padding", m_axis_tdata[OutTdataW-1:PadLsb], '0);
        if (m_axis_tlast != want.last)
          report_mismatch("last_channel", m_axis_tlast, want.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte source
  // ---------------------------------------------------------------------------
  // tvalid stays high between back-to-back beats; it drops only while idling or draining.
  task automatic send_byte(input logic [7:0] b);
    while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    deframe_byte(b);
  endtask

  // Source goes quiet until every predicted beat has been taken.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_header(input logic [TimeW-1:0] stamp, input logic [7:0] ttl_in,
                             input logic [7:0] ttl_out);
    for (int k = 0; k < 6; k++) send_byte({stamp[7*k +: 7], 1'b1});
    send_byte(ttl_in);
    send_byte(ttl_out);
  endtask

  task automatic send_triples(input int unsigned n);
    for (int unsigned k = 0; k < 3 * n; k++) send_byte(8'($urandom));
  endtask

  // Marked bytes that stop short of six, closed by an unmarked one.
  task automatic send_broken_hunt();
    int unsigned n;
    n = $urandom_range(0, 5);
    repeat (n) send_byte(8'($urandom) | 8'h01);
    send_byte(8'($urandom) & 8'hFE);
  endtask

  task automatic send_random_frame(input bit pause_midway);
    logic [TimeW-1:0] stamp;
    logic [7:0]       ttl_out;
    stamp   = TimeW'({$urandom, $urandom});
    ttl_out = $urandom_range(0, 1) ? 8'($urandom) : 8'h00;
    send_header(stamp, 8'($urandom), ttl_out);
    for (int k = 0; k < 4; k++) begin
      send_triples(Triples / 4);
      if (pause_midway) wait_drained();
    end
  endtask

  task automatic random_traffic(input bit pause_midway);
    send_broken_hunt();
    send_random_frame(pause_midway);
    send_broken_hunt();
  endtask

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  task automatic apb_xfer(input bit wr, input sfd_reg_e r, input logic [PdataW-1:0] wdata,
                          output logic [PdataW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {r, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(input sfd_reg_e r, input logic [PdataW-1:0] want);
    logic [PdataW-1:0] rd;
    apb_xfer(1'b0, r, '0, rd);
    if (rd != want) report_mismatch({r.name(), " readback"}, rd, want);
  endtask

  // Only called with the block idle; the prediction follows the write at once.
  task automatic set_config(input logic [GainW-1:0] gain, input logic [OffsetW-1:0] offset,
                            input logic [CoefW-1:0] coef);
    logic [PdataW-1:0] unused;
    wait_drained();
    apb_xfer(1'b1, REG_GAIN, PdataW'(gain), unused);
    apb_xfer(1'b1, REG_OFFSET, PdataW'(offset), unused);
    apb_xfer(1'b1, REG_COEF, PdataW'(coef), unused);
    check_reg(REG_GAIN, PdataW'(gain));
    check_reg(REG_OFFSET, PdataW'(offset));
    check_reg(REG_COEF, PdataW'(coef));
    gain_m   = gain;
    offset_m = offset;
    coef_m   = coef;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_register_reset();
    check_reg(REG_GAIN, PdataW'(GainReset));
    check_reg(REG_OFFSET, PdataW'(OffsetReset));
    check_reg(REG_COEF, PdataW'(CoefReset));
  endtask

  // Five marked bytes then an unmarked one: run and stamp must start over.
  task automatic test_hunt_recovery();
    repeat (5) send_byte(8'hFF);
    send_byte(8'hFE);
  endtask

  // Full-scale stamp, TTL out zero, then max, zero and repair-bit samples with
  // unmarked bytes inside the data; rest of the frame is random.
  task automatic test_directed_frame();
    send_header({TimeW{1'b1}}, 8'hFF, 8'h00);
    send_byte(8'hFF); send_byte(8'hFF); send_byte(8'hFF);  // sample 0xFFFF
    send_byte(8'h5A); send_byte(8'hA5); send_byte(8'h3C);  // unused triple
    send_byte(8'h00); send_byte(8'h00); send_byte(8'hF9);  // sample 0, repair bits clear
    send_byte(8'hC3); send_byte(8'h00); send_byte(8'hFF);  // unused triple
    send_byte(8'h00); send_byte(8'h00); send_byte(8'h06);  // repair bits give 0x0101
    send_triples(Triples - 5);
  endtask

  // Full gain, no offset, pole at zero: output is the sample step, which saturates.
  task automatic test_saturation_no_idle();
    set_config(16'hFFFF, 24'h000000, 24'h000000);
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    random_traffic(1'b0);
  endtask

  task automatic test_sender_gaps();
    set_config(16'h0000, 24'hFFFFFF, 24'hFFFFFF);
    src_idle_pct  = 49;
    snk_stall_pct = 0;
    random_traffic(1'b0);
  endtask

  task automatic test_receiver_stalls();
    set_config(GainW'($urandom), OffsetW'($urandom), CoefW'($urandom));
    src_idle_pct  = 0;
    snk_stall_pct = 49;
    random_traffic(1'b0);
  endtask

  // Light idling on both sides; the source also stops mid-frame until drained.
  task automatic test_mixed_with_pauses();
    set_config(16'hFFFF, 24'hFFFFFF, CoefW'($urandom));
    src_idle_pct  = 8;
    snk_stall_pct = 8;
    random_traffic(1'b1);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_reset();
    test_hunt_recovery();
    test_directed_frame();
    test_saturation_no_idle();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_with_pauses();

    wait_drained();
    if (error_count == 0) begin
      $display("tb_sample_frame_deframer_highpass passed");
    end else begin
      $display("tb_sample_frame_deframer_highpass failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of about 1050 bytes.
  initial begin
    #10_000_000;
    $display("tb_sample_frame_deframer_highpass failed");
    $finish;
  end

endmodule

@@ sample_frame_deframer_highpass.f @@
hw/rtl/sfd_pkg.sv
hw/rtl/sfd_regs.sv
hw/rtl/sfd_ctrl.sv
hw/rtl/sfd_dp.sv
hw/rtl/sample_frame_deframer_highpass.sv
bench/tb_sample_frame_deframer_highpass.sv
